### rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the lru key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W             = 16;
  localparam int DATA_W            = 32;
  localparam int STAMP_W           = 32;
  localparam int CACHE_ENTRIES_DEF = 16;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

### rtl/lkv_in_if.sv
// ----------------------------------------------------------------------------
// lkv_in_if
// Request channel of the lru key/value cache.
// ----------------------------------------------------------------------------
interface lkv_in_if;

  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [lkv_pkg::KEY_W-1:0]  key;
  logic [lkv_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output op, output key, output data_in, input ready);
  modport sink   (input valid, input op, input key, input data_in, output ready);

endinterface

### rtl/lkv_out_if.sv
// ----------------------------------------------------------------------------
// lkv_out_if
// Result channel of the lru key/value cache.
// ----------------------------------------------------------------------------
interface lkv_out_if;

  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lkv_pkg::DATA_W-1:0] data_out;
  logic                       evicted;

  modport source (output valid, output hit, output data_out, output evicted, input ready);
  modport sink   (input valid, input hit, input data_out, input evicted, output ready);

endinterface

### rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A lookup returns the stored data on a hit and refreshes the entry's stamp;
// an insert updates a present key, fills the next free slot, or replaces the
// entry with the oldest stamp once the store is full (lowest index on ties).
// Entries live in one ram with a single read port, so every request scans the
// filled entries one per cycle. The request channel is not ready while a
// request is in progress. Results sit in an output register; a request
// finishes only once the previous result has been taken. No clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int CACHE_ENTRIES = lkv_pkg::CACHE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lkv_in_if.sink    in_chan,
  lkv_out_if.source out_chan
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  lkv_pkg::state_t state_r, state_nxt;

  logic                          op_r, op_nxt;
  logic [lkv_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [lkv_pkg::DATA_W-1:0]    data_r, data_nxt;

  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [lkv_pkg::STAMP_W-1:0]   clock_r, clock_nxt;

  logic [IDX_W-1:0]              addr_r, addr_nxt;
  logic                          issue_done_r, issue_done_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]              rd_idx_r, rd_idx_nxt;

  logic                          found_r, found_nxt;
  logic [IDX_W-1:0]              match_idx_r, match_idx_nxt;
  logic [lkv_pkg::DATA_W-1:0]    match_data_r, match_data_nxt;
  logic [IDX_W-1:0]              min_idx_r, min_idx_nxt;
  logic [lkv_pkg::STAMP_W-1:0]   min_stamp_r, min_stamp_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [lkv_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                          out_evicted_r, out_evicted_nxt;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  lkv_pkg::entry_t               ram_wdata;
  lkv_pkg::entry_t               ram_rdata;

  logic                          accept;
  logic                          out_take;
  logic                          proceed;
  logic                          store_full;
  logic [lkv_pkg::STAMP_W-1:0]   clock_inc;

  lkv_ram #(
    .WIDTH ($bits(lkv_pkg::entry_t)),
    .DEPTH (CACHE_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign in_chan.ready     = (state_r == lkv_pkg::ST_IDLE);
  assign accept            = in_chan.valid && in_chan.ready;
  assign out_take          = out_valid_r && out_chan.ready;
  assign proceed           = !out_valid_r || out_chan.ready;
  assign store_full        = (fill_r == CNT_W'(CACHE_ENTRIES));
  assign clock_inc         = (clock_r == '1) ? clock_r : clock_r + 1'b1;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.hit      = out_hit_r;
  assign out_chan.data_out = out_data_r;
  assign out_chan.evicted  = out_evicted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lkv_pkg::ST_IDLE;
      fill_r       <= '0;
      clock_r      <= '0;
      rd_vld_r     <= 1'b0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      clock_r      <= clock_nxt;
      rd_vld_r     <= rd_vld_nxt;
      issue_done_r <= issue_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    data_r        <= data_nxt;
    addr_r        <= addr_nxt;
    rd_idx_r      <= rd_idx_nxt;
    found_r       <= found_nxt;
    match_idx_r   <= match_idx_nxt;
    match_data_r  <= match_data_nxt;
    min_idx_r     <= min_idx_nxt;
    min_stamp_r   <= min_stamp_nxt;
    out_hit_r     <= out_hit_nxt;
    out_data_r    <= out_data_nxt;
    out_evicted_r <= out_evicted_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    data_nxt        = data_r;
    fill_nxt        = fill_r;
    clock_nxt       = clock_r;
    addr_nxt        = addr_r;
    issue_done_nxt  = issue_done_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = addr_r;
    found_nxt       = found_r;
    match_idx_nxt   = match_idx_r;
    match_data_nxt  = match_data_r;
    min_idx_nxt     = min_idx_r;
    min_stamp_nxt   = min_stamp_r;
    out_valid_nxt   = out_take ? 1'b0 : out_valid_r;
    out_hit_nxt     = out_hit_r;
    out_data_nxt    = out_data_r;
    out_evicted_nxt = out_evicted_r;
    ram_we          = 1'b0;
    ram_waddr       = match_idx_r;
    ram_wdata       = '{key: key_r, data: data_r, stamp: clock_r};

    // compare stage, one entry per cycle
    if (rd_vld_r) begin
      if (!found_r && ram_rdata.key == key_r) begin
        found_nxt      = 1'b1;
        match_idx_nxt  = rd_idx_r;
        match_data_nxt = ram_rdata.data;
      end
      if (rd_idx_r == '0 || ram_rdata.stamp < min_stamp_r) begin
        min_idx_nxt   = rd_idx_r;
        min_stamp_nxt = ram_rdata.stamp;
      end
    end

    case (state_r)
      lkv_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_chan.op;
          key_nxt        = in_chan.key;
          data_nxt       = in_chan.data_in;
          addr_nxt       = '0;
          issue_done_nxt = (fill_r == '0);
          found_nxt      = 1'b0;
          state_nxt      = lkv_pkg::ST_SCAN;
        end
      end
      lkv_pkg::ST_SCAN: begin
        if (!issue_done_r) begin
          rd_vld_nxt = 1'b1;
          if (CNT_W'(addr_r) + CNT_W'(1) == fill_r) begin
            issue_done_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end else if (!rd_vld_r) begin
          state_nxt = lkv_pkg::ST_WRITE;
        end
      end
      lkv_pkg::ST_WRITE: begin
        if (proceed) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = found_r;
          out_data_nxt    = '0;
          out_evicted_nxt = 1'b0;
          if (op_r == lkv_pkg::OP_INSERT) begin
            ram_we    = 1'b1;
            clock_nxt = clock_inc;
            if (found_r) begin
              ram_waddr = match_idx_r;
            end else if (!store_full) begin
              ram_waddr = fill_r[IDX_W-1:0];
              fill_nxt  = fill_r + 1'b1;
            end else begin
              ram_waddr       = min_idx_r;
              out_evicted_nxt = 1'b1;
            end
          end else if (found_r) begin
            ram_we       = 1'b1;
            ram_waddr    = match_idx_r;
            ram_wdata    = '{key: key_r, data: match_data_r, stamp: clock_r};
            clock_nxt    = clock_inc;
            out_data_nxt = match_data_r;
          end
          state_nxt = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the lru key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_hit,
  input logic [lkv_pkg::DATA_W-1:0] out_data_out,
  input logic                       out_evicted
);

  // held result stays put until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out)
      && $stable(out_hit) && $stable(out_evicted))
    else $error("result changed while stalled");

  // busy once a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a request");

  // a miss never carries data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_data_out == '0)
    else $error("data on a miss");

  // eviction only on an insert miss
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && out_data_out == '0)
    else $error("eviction flagged on a hit or with data");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_hit      (out_chan.hit),
  .out_data_out (out_chan.data_out),
  .out_evicted  (out_chan.evicted)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru key/value cache testbench
// Drives lookup and insert requests into lru_key_value_cache and predicts each
// reply from a local copy of the entries, stamps and access counter. A short
// directed part covers the extremes, key update, a full store and eviction.
// The random part follows with shifting key pools, random idling on both
// channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                       hit;
  logic [lkv_pkg::DATA_W-1:0] data;
  logic                       evicted;
} cache_reply_t;

class cache_scoreboard;

  logic [lkv_pkg::KEY_W-1:0]   stored_keys  [lkv_pkg::CACHE_ENTRIES_DEF];
  logic [lkv_pkg::DATA_W-1:0]  stored_data  [lkv_pkg::CACHE_ENTRIES_DEF];
  logic [lkv_pkg::STAMP_W-1:0] stored_stamps[lkv_pkg::CACHE_ENTRIES_DEF];
  int                          filled;
  logic [lkv_pkg::STAMP_W-1:0] access_clock;
  cache_reply_t                awaited_replies[$];
  int mismatches, strays;
  int lookups, hits, inserts, updates, evictions;

  function new();
    filled       = 0;
    access_clock = '0;
    mismatches   = 0;
    strays       = 0;
    lookups      = 0;
    hits         = 0;
    inserts      = 0;
    updates      = 0;
    evictions    = 0;
  endfunction

  function logic [lkv_pkg::STAMP_W-1:0] take_stamp();
    logic [lkv_pkg::STAMP_W-1:0] s;
    s = access_clock;
    if (access_clock != '1) access_clock = access_clock + 1'b1;
    return s;
  endfunction

  function cache_reply_t predict_access(logic op, logic [lkv_pkg::KEY_W-1:0] key,
                                        logic [lkv_pkg::DATA_W-1:0] data);
    cache_reply_t                r;
    int                          found;
    int                          slot;
    logic [lkv_pkg::STAMP_W-1:0] stamp;
    r     = '0;
    found = -1;
    for (int i = 0; i < filled; i++) begin
      if (found < 0 && stored_keys[i] == key) found = i;
    end
    if (op == lkv_pkg::OP_LOOKUP) begin
      if (found >= 0) begin
        r.hit                = 1'b1;
        r.data               = stored_data[found];
        stored_stamps[found] = take_stamp();
      end
    end else begin
      stamp = take_stamp();
      if (found >= 0) begin
        r.hit = 1'b1;
        slot  = found;
      end else if (filled < lkv_pkg::CACHE_ENTRIES_DEF) begin
        slot   = filled;
        filled = filled + 1;
      end else begin
        slot = 0;
        for (int i = 1; i < lkv_pkg::CACHE_ENTRIES_DEF; i++) begin
          if (stored_stamps[i] < stored_stamps[slot]) slot = i;
        end
        r.evicted = 1'b1;
      end
      stored_keys[slot]   = key;
      stored_data[slot]   = data;
      stored_stamps[slot] = stamp;
    end
    return r;
  endfunction

  function void note_request(logic op, logic [lkv_pkg::KEY_W-1:0] key,
                             logic [lkv_pkg::DATA_W-1:0] data);
    cache_reply_t r;
    r = predict_access(op, key, data);
    awaited_replies.push_back(r);
    if (op == lkv_pkg::OP_LOOKUP) begin
      lookups++;
      if (r.hit) hits++;
    end else begin
      inserts++;
      if (r.hit) updates++;
      if (r.evicted) evictions++;
    end
  endfunction

  function void check_result(logic hit, logic [lkv_pkg::DATA_W-1:0] data, logic evicted);
    cache_reply_t want;
    if (awaited_replies.size() == 0) begin
      strays++;
      if (strays + mismatches <= 10)
        $display("error: reply hit=%0b data=%h evicted=%0b with no request pending",
                 hit, data, evicted);
    end else begin
      want = awaited_replies.pop_front();
      if (want.hit !== hit || want.data !== data || want.evicted !== evicted) begin
        mismatches++;
        if (strays + mismatches <= 10)
          $display("error: expected hit=%0b data=%h evicted=%0b, got hit=%0b data=%h evicted=%0b",
                   want.hit, want.data, want.evicted, hit, data, evicted);
      end
    end
  endfunction

  function int pending();
    return awaited_replies.size();
  endfunction

  function int faults();
    return mismatches + strays + awaited_replies.size();
  endfunction

endclass

module testbench;

  localparam int ENTRIES        = lkv_pkg::CACHE_ENTRIES_DEF;
  localparam int IDLE_MAX       = 18;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_ITEM   = 600;
  localparam int RANDOM_ITEMS   = 1725;
  localparam int CALM_ITEMS     = 250;
  localparam int POOL_DEPTH     = 40;
  localparam int SETTLE_CYCLES  = 2 * (ENTRIES + 4);
  localparam int WATCHDOG_LIMIT = HOLD_CYCLES + 20 * (ENTRIES + 4 + 2 * IDLE_MAX);

  logic clk;
  logic rst_n;

  lkv_in_if  in_chan();
  lkv_out_if out_chan();

  lru_key_value_cache dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cache_scoreboard ledger = new();

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_results;
  int quiet_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic send_request(input logic op, input logic [lkv_pkg::KEY_W-1:0] key,
                              input logic [lkv_pkg::DATA_W-1:0] data);
    in_chan.valid   <= 1'b1;
    in_chan.op      <= op;
    in_chan.key     <= key;
    in_chan.data_in <= data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    ledger.note_request(op, key, data);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    send_request(lkv_pkg::OP_LOOKUP, 16'h0000, $urandom);
    send_request(lkv_pkg::OP_INSERT, 16'h0000, 32'h0000_0000);
    send_request(lkv_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(lkv_pkg::OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    send_request(lkv_pkg::OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
    send_request(lkv_pkg::OP_INSERT, 16'hFFFF, 32'h5A5A_A5A5);
    send_request(lkv_pkg::OP_LOOKUP, 16'hFFFF, $urandom);
    // lookup miss leaves stamps alone
    send_request(lkv_pkg::OP_LOOKUP, 16'h1234, $urandom);
    for (int k = 1; k <= ENTRIES - 2; k++)
      send_request(lkv_pkg::OP_INSERT, lkv_pkg::KEY_W'(k), $urandom);
    // refresh key 0 so key ffff becomes the oldest
    send_request(lkv_pkg::OP_LOOKUP, 16'h0000, $urandom);
    send_request(lkv_pkg::OP_INSERT, 16'h8000, $urandom);
    send_request(lkv_pkg::OP_LOOKUP, 16'hFFFF, $urandom);
  endtask

  task automatic run_random();
    logic [lkv_pkg::KEY_W-1:0] key_pool[POOL_DEPTH];
    int                        pool_size;
    logic                      op;
    logic [lkv_pkg::KEY_W-1:0] key;
    for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = lkv_pkg::KEY_W'($urandom);
    pool_size = 20;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        pool_size = $urandom_range(6, POOL_DEPTH);
        repeat (8) key_pool[$urandom_range(0, POOL_DEPTH - 1)] = lkv_pkg::KEY_W'($urandom);
        send_idle_pct = $urandom_range(0, 2) * 20;
        recv_idle_pct = $urandom_range(0, 2) * 20;
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == HOLD_AT_ITEM) hold_results = 1'b1;
      op  = $urandom_range(0, 1) ? lkv_pkg::OP_INSERT : lkv_pkg::OP_LOOKUP;
      key = ($urandom_range(0, 4) == 0) ? lkv_pkg::KEY_W'($urandom)
                                         : key_pool[$urandom_range(0, pool_size - 1)];
      send_request(op, key, $urandom);
    end
  endtask

  // result side: random stalls plus one long hold
  initial begin
    forever begin
      if (hold_results) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      ledger.check_result(out_chan.hit, out_chan.data_out, out_chan.evicted);
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    hold_results    = 1'b0;
    send_idle_pct   = 20;
    recv_idle_pct   = 20;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.op      <= lkv_pkg::OP_LOOKUP;
    in_chan.key     <= '0;
    in_chan.data_in <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_chan.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d lookups (%0d hits) and %0d inserts (%0d updates, %0d evictions)",
             ledger.lookups, ledger.hits, ledger.inserts, ledger.updates, ledger.evictions);
    $display("%0d mismatches, %0d unexpected replies, one hold of %0d cycles on the result side",
             ledger.mismatches, ledger.strays, HOLD_CYCLES);
    if (ledger.faults() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### lru_key_value_cache.f
rtl/lkv_pkg.sv
rtl/lkv_in_if.sv
rtl/lkv_out_if.sv
rtl/lkv_ram.sv
rtl/lru_key_value_cache.sv
rtl/lkv_checker.sv
tb/testbench.sv
